### rtl/vfv_pkg.sv
// Package with the shared types, codes and constants of the voxel face editor.
`timescale 1ns / 1ps

package vfv_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_GRID_SIDE  = 1'b0;
  localparam logic REG_CULLING_ON = 1'b1;

  // Operation selector of an input item.
  localparam logic FUNC_PLACE   = 1'b0;
  localparam logic FUNC_DESTROY = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DESTROYED = 2'd0;
  localparam logic [1:0] ST_PLACED    = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;

  // Face codes.
  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_LEFT   = 3'd1;
  localparam logic [2:0] FACE_BACK   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  // Voxel index taken from a non-negative 15-bit pick id, and its division by six.
  localparam int VW = 13;
  localparam logic [16:0] DIV6_MUL = 17'd43691;
  localparam int DIV6_SHIFT = 18;
  localparam logic [14:0] COUNT_MAX = 15'd32767;
  localparam logic [3:0] DIV_LAST = 4'd12;

  typedef struct packed {
    logic               func;
    logic signed [15:0] pick_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] changed_voxel;
    logic [14:0] visible_faces;
  } out_item_t;

  typedef enum logic [4:0] {
    S_FILL_INIT, S_FILL_CUBE, S_FILL_CNT, S_FILL, S_IDLE, S_MUL, S_SPLIT, S_CHK,
    S_RDV_W, S_DIV1, S_DIV1E, S_DIV2, S_DIV2E, S_EDIT, S_PW, S_NB, S_NBW, S_UPD,
    S_DONE, S_IGN
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_SQ, OP_CUBE, OP_FCOUNT, OP_FILL, OP_LOAD, OP_MUL, OP_SPLIT, OP_RDV,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_SAVE1, OP_DIV_SAVE2, OP_CLR, OP_RDN, OP_SET,
    OP_NBRD, OP_UPD, OP_OUT, OP_OUT_IGN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] face;
  } cmd_t;

  typedef struct packed {
    logic side_wr;
    logic fill_last;
    logic pick_ok;
    logic rd_solid;
    logic nb_in;
    logic out_free;
    logic destroy;
  } sts_t;

endpackage

### rtl/vfv_ctrl.sv
// Controller state machine that sequences refills and voxel edits.
`timescale 1ns / 1ps

module vfv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vfv_pkg::sts_t sts,
  output vfv_pkg::cmd_t cmd
);

  vfv_pkg::ctrl_state_t state_r, state_nxt;
  logic [3:0] dc_r, dc_nxt;
  logic [2:0] fc_r, fc_nxt;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfv_pkg::S_FILL_INIT;
      dc_r    <= '0;
      fc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      dc_r    <= dc_nxt;
      fc_r    <= fc_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    dc_nxt    = dc_r;
    fc_nxt    = fc_r;
    cmd.op    = vfv_pkg::OP_NOP;
    cmd.face  = fc_r;
    in_ready  = 1'b0;
    unique case (state_r)
      vfv_pkg::S_FILL_INIT: begin
        cmd.op = vfv_pkg::OP_SQ;
        state_nxt = vfv_pkg::S_FILL_CUBE;
      end
      vfv_pkg::S_FILL_CUBE: begin
        cmd.op = vfv_pkg::OP_CUBE;
        state_nxt = vfv_pkg::S_FILL_CNT;
      end
      vfv_pkg::S_FILL_CNT: begin
        cmd.op = vfv_pkg::OP_FCOUNT;
        state_nxt = vfv_pkg::S_FILL;
      end
      vfv_pkg::S_FILL: begin
        cmd.op = vfv_pkg::OP_FILL;
        if (sts.fill_last) state_nxt = vfv_pkg::S_IDLE;
      end
      vfv_pkg::S_IDLE: begin
        in_ready = !sts.side_wr;
        if (in_valid && !sts.side_wr) begin
          cmd.op = vfv_pkg::OP_LOAD;
          state_nxt = vfv_pkg::S_MUL;
        end
      end
      vfv_pkg::S_MUL: begin
        cmd.op = vfv_pkg::OP_MUL;
        state_nxt = vfv_pkg::S_SPLIT;
      end
      vfv_pkg::S_SPLIT: begin
        cmd.op = vfv_pkg::OP_SPLIT;
        state_nxt = vfv_pkg::S_CHK;
      end
      vfv_pkg::S_CHK: begin
        if (sts.pick_ok) begin
          cmd.op = vfv_pkg::OP_RDV;
          state_nxt = vfv_pkg::S_RDV_W;
        end else begin
          state_nxt = vfv_pkg::S_IGN;
        end
      end
      vfv_pkg::S_RDV_W: begin
        if (sts.rd_solid) begin
          cmd.op = vfv_pkg::OP_DIV_INIT;
          dc_nxt = '0;
          state_nxt = vfv_pkg::S_DIV1;
        end else begin
          state_nxt = vfv_pkg::S_IGN;
        end
      end
      vfv_pkg::S_DIV1: begin
        cmd.op = vfv_pkg::OP_DIV_STEP;
        dc_nxt = dc_r + 4'd1;
        if (dc_r == vfv_pkg::DIV_LAST) state_nxt = vfv_pkg::S_DIV1E;
      end
      vfv_pkg::S_DIV1E: begin
        cmd.op = vfv_pkg::OP_DIV_SAVE1;
        dc_nxt = '0;
        state_nxt = vfv_pkg::S_DIV2;
      end
      vfv_pkg::S_DIV2: begin
        cmd.op = vfv_pkg::OP_DIV_STEP;
        dc_nxt = dc_r + 4'd1;
        if (dc_r == vfv_pkg::DIV_LAST) state_nxt = vfv_pkg::S_DIV2E;
      end
      vfv_pkg::S_DIV2E: begin
        cmd.op = vfv_pkg::OP_DIV_SAVE2;
        state_nxt = vfv_pkg::S_EDIT;
      end
      vfv_pkg::S_EDIT: begin
        fc_nxt = '0;
        if (sts.destroy) begin
          cmd.op = vfv_pkg::OP_CLR;
          state_nxt = vfv_pkg::S_NB;
        end else if (sts.nb_in) begin
          cmd.op = vfv_pkg::OP_RDN;
          state_nxt = vfv_pkg::S_PW;
        end else begin
          state_nxt = vfv_pkg::S_IGN;
        end
      end
      vfv_pkg::S_PW: begin
        if (sts.rd_solid) begin
          state_nxt = vfv_pkg::S_IGN;
        end else begin
          cmd.op = vfv_pkg::OP_SET;
          state_nxt = vfv_pkg::S_NB;
        end
      end
      vfv_pkg::S_NB: begin
        cmd.op = vfv_pkg::OP_NBRD;
        fc_nxt = fc_r + 3'd1;
        if (fc_r == vfv_pkg::FACE_BOTTOM) state_nxt = vfv_pkg::S_NBW;
      end
      vfv_pkg::S_NBW: begin
        state_nxt = vfv_pkg::S_UPD;
      end
      vfv_pkg::S_UPD: begin
        cmd.op = vfv_pkg::OP_UPD;
        state_nxt = vfv_pkg::S_DONE;
      end
      vfv_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.op = vfv_pkg::OP_OUT;
          state_nxt = vfv_pkg::S_IDLE;
        end
      end
      vfv_pkg::S_IGN: begin
        if (sts.out_free) begin
          cmd.op = vfv_pkg::OP_OUT_IGN;
          state_nxt = vfv_pkg::S_IDLE;
        end
      end
      default: state_nxt = vfv_pkg::S_FILL_INIT;
    endcase
    // A side write restarts the refill from any state.
    if (sts.side_wr) state_nxt = vfv_pkg::S_FILL_INIT;
  end

  // Divider step count stays within one quotient.
  a_dc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vfv_pkg::S_DIV1 || state_r == vfv_pkg::S_DIV2) |-> dc_r <= vfv_pkg::DIV_LAST)
    else $error("divider step count overran");

  // The neighbour scan issues exactly six reads before the count update.
  a_nb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vfv_pkg::S_NBW) |-> $past(fc_r) == vfv_pkg::FACE_BOTTOM)
    else $error("neighbour scan ended early");

  // An item is only taken while idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == vfv_pkg::S_MUL || state_r == vfv_pkg::S_FILL_INIT))
    else $error("item taken outside idle");

endmodule

### rtl/vfv_dpath.sv
// Datapath: occupancy memory, serial divider, neighbour logic, face count and result register.
`timescale 1ns / 1ps

module vfv_dpath #(
  parameter int MAX_SIDE = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vfv_pkg::cmd_t      cmd,
  output vfv_pkg::sts_t      sts,
  input  vfv_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata,
  input  logic               out_ready,
  output logic               out_valid,
  output vfv_pkg::out_item_t out_data
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int FW = 3 * SW;
  localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int CW = (FW > vfv_pkg::VW) ? FW : vfv_pkg::VW;
  localparam int GW = (FW + 3 > 16) ? FW + 3 : 16;
  localparam int SIDE_RST = (MAX_SIDE < 16) ? MAX_SIDE : 16;

  logic              occ_mem [MEM_DEPTH];
  logic [SW-1:0]     side_r;
  logic              cull_r, cull_fill_r;
  logic [2*SW-1:0]   s2_r;
  logic [FW-1:0]     s3_r;
  logic [AW-1:0]     fill_a_r;
  logic [14:0]       count_r;
  logic              func_r;
  logic [15:0]       pick_r;
  logic [31:0]       prod_r;
  logic [vfv_pkg::VW-1:0] v_r, dvd_r;
  logic [2:0]        f_r;
  logic [SW-1:0]     rem_r, cx_r, cy_r, cz_r;
  logic [AW-1:0]     c_r;
  logic              rdata_r, nbrd_r, nbin_r;
  logic [2:0]        k_r;
  logic              out_valid_r;
  vfv_pkg::out_item_t out_r;

  logic              side_wr;
  logic [SW:0]       rem_w, trial;
  logic              qbit;
  logic [2:0]        face;
  logic              nb_in;
  logic [AW-1:0]     nb_idx;
  logic [SW-1:0]     nx, ny, nz, s_last;
  logic [GW-1:0]     fbase, fc6;
  logic [15:0]       six_v;
  logic signed [17:0] delta, sum;
  logic [AW-1:0]     rd_addr;

  assign side_wr = cfg_we && (cfg_index == vfv_pkg::REG_GRID_SIDE);
  assign s_last  = side_r - SW'(1);

  // Configuration registers; a side write is clamped to the legal range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SW'(SIDE_RST);
      cull_r      <= 1'b1;
      cull_fill_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == vfv_pkg::REG_GRID_SIDE) begin
        cull_fill_r <= cull_r;
        if (cfg_wdata == 5'd0) side_r <= SW'(1);
        else if (int'(cfg_wdata) > MAX_SIDE) side_r <= SW'(MAX_SIDE);
        else side_r <= SW'(cfg_wdata);
      end else begin
        cull_r <= cfg_wdata[0];
      end
    end
  end

  // One restoring divider step by the grid side.
  always_comb begin
    rem_w = {rem_r, dvd_r[vfv_pkg::VW-1]};
    trial = rem_w - {1'b0, side_r};
    qbit  = (rem_w >= {1'b0, side_r});
  end

  // Neighbour across the selected face of the centre voxel.
  always_comb begin
    face   = (cmd.op == vfv_pkg::OP_NBRD) ? cmd.face : f_r;
    nx     = cx_r;
    ny     = cy_r;
    nz     = cz_r;
    nb_in  = 1'b0;
    nb_idx = c_r;
    unique case (face)
      vfv_pkg::FACE_FRONT: begin
        nb_in = (cz_r != '0); nz = cz_r - SW'(1); nb_idx = c_r - AW'(1);
      end
      vfv_pkg::FACE_LEFT: begin
        nb_in = (cx_r != '0); nx = cx_r - SW'(1); nb_idx = c_r - AW'(s2_r);
      end
      vfv_pkg::FACE_BACK: begin
        nb_in = (cz_r != s_last); nz = cz_r + SW'(1); nb_idx = c_r + AW'(1);
      end
      vfv_pkg::FACE_RIGHT: begin
        nb_in = (cx_r != s_last); nx = cx_r + SW'(1); nb_idx = c_r + AW'(s2_r);
      end
      vfv_pkg::FACE_TOP: begin
        nb_in = (cy_r != '0); ny = cy_r - SW'(1); nb_idx = c_r - AW'(side_r);
      end
      default: begin
        nb_in = (cy_r != s_last); ny = cy_r + SW'(1); nb_idx = c_r + AW'(side_r);
      end
    endcase
  end

  // Refill count, six times the area or the volume, and six times the voxel index.
  always_comb begin
    fbase = cull_fill_r ? GW'(s2_r) : GW'(s3_r);
    fc6   = (fbase << 2) + (fbase << 1);
    six_v = {3'b000, v_r} + {3'b000, v_r} + {3'b000, v_r}
          + {3'b000, v_r} + {3'b000, v_r} + {3'b000, v_r};
  end

  // Count change for the present edit.
  always_comb begin
    if (cull_r) begin
      if (func_r == vfv_pkg::FUNC_DESTROY) delta = 18'($signed({1'b0, k_r, 1'b0})) - 18'sd6;
      else delta = 18'sd6 - 18'($signed({1'b0, k_r, 1'b0}));
    end else begin
      delta = (func_r == vfv_pkg::FUNC_DESTROY) ? -18'sd6 : 18'sd6;
    end
    sum = $signed({3'b000, count_r}) + delta;
  end

  // Read address of the occupancy memory.
  always_comb begin
    rd_addr = nb_idx;
    if (cmd.op == vfv_pkg::OP_RDV) rd_addr = AW'(v_r);
  end

  // Occupancy memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.op == vfv_pkg::OP_FILL) occ_mem[fill_a_r] <= 1'b1;
    else if (cmd.op == vfv_pkg::OP_CLR) occ_mem[c_r] <= 1'b0;
    else if (cmd.op == vfv_pkg::OP_SET) occ_mem[c_r] <= 1'b1;
    rdata_r <= occ_mem[rd_addr];
  end

  // Control flags of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      nbrd_r      <= 1'b0;
    end else begin
      nbrd_r <= (cmd.op == vfv_pkg::OP_NBRD);
      if (cmd.op == vfv_pkg::OP_OUT || cmd.op == vfv_pkg::OP_OUT_IGN) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers, stepped by the controller's commands.
  always_ff @(posedge clk) begin
    nbin_r <= nb_in;
    if (nbrd_r && rdata_r && nbin_r) k_r <= k_r + 3'd1;
    unique case (cmd.op)
      vfv_pkg::OP_SQ:     s2_r <= side_r * side_r;
      vfv_pkg::OP_CUBE:   s3_r <= FW'(s2_r * side_r);
      vfv_pkg::OP_FCOUNT: begin
        fill_a_r <= '0;
        count_r  <= (fc6 > GW'(vfv_pkg::COUNT_MAX)) ? vfv_pkg::COUNT_MAX : fc6[14:0];
      end
      vfv_pkg::OP_FILL:   fill_a_r <= fill_a_r + AW'(1);
      vfv_pkg::OP_LOAD: begin
        func_r <= in_data.func;
        pick_r <= in_data.pick_id;
      end
      vfv_pkg::OP_MUL:    prod_r <= 32'(pick_r[14:0]) * 32'(vfv_pkg::DIV6_MUL);
      vfv_pkg::OP_SPLIT: begin
        v_r <= prod_r[vfv_pkg::DIV6_SHIFT +: vfv_pkg::VW];
      end
      vfv_pkg::OP_DIV_INIT: begin
        f_r   <= 3'({1'b0, pick_r[14:0]} - six_v);
        dvd_r <= v_r;
        rem_r <= '0;
      end
      vfv_pkg::OP_DIV_STEP: begin
        rem_r <= qbit ? trial[SW-1:0] : rem_w[SW-1:0];
        dvd_r <= {dvd_r[vfv_pkg::VW-2:0], qbit};
      end
      vfv_pkg::OP_DIV_SAVE1: begin
        cz_r  <= rem_r;
        rem_r <= '0;
      end
      vfv_pkg::OP_DIV_SAVE2: begin
        cy_r <= rem_r;
        cx_r <= SW'(dvd_r);
        c_r  <= AW'(v_r);
      end
      vfv_pkg::OP_CLR:    k_r <= '0;
      vfv_pkg::OP_SET:    k_r <= '0;
      vfv_pkg::OP_RDN: begin
        c_r  <= nb_idx;
        cx_r <= nx;
        cy_r <= ny;
        cz_r <= nz;
      end
      vfv_pkg::OP_UPD: begin
        if (sum < 0) count_r <= '0;
        else if (sum > $signed({3'b000, vfv_pkg::COUNT_MAX})) count_r <= vfv_pkg::COUNT_MAX;
        else count_r <= sum[14:0];
      end
      vfv_pkg::OP_OUT: begin
        out_r.status        <= (func_r == vfv_pkg::FUNC_DESTROY) ? vfv_pkg::ST_DESTROYED
                                                                 : vfv_pkg::ST_PLACED;
        out_r.changed_voxel <= 12'(c_r);
        out_r.visible_faces <= count_r;
      end
      vfv_pkg::OP_OUT_IGN: begin
        out_r.status        <= vfv_pkg::ST_IGNORED;
        out_r.changed_voxel <= '0;
        out_r.visible_faces <= count_r;
      end
      default: ;
    endcase
  end

  // Status towards the controller.
  always_comb begin
    sts.side_wr   = side_wr;
    sts.fill_last = (FW'(fill_a_r) == s3_r - FW'(1));
    sts.pick_ok   = !pick_r[15] && (CW'(v_r) < CW'(s3_r));
    sts.rd_solid  = rdata_r;
    sts.nb_in     = nb_in;
    sts.out_free  = !out_valid_r || out_ready;
    sts.destroy   = (func_r == vfv_pkg::FUNC_DESTROY);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/voxel_face_visibility_editor_core.sv
// Top level of the voxel face visibility editor.
`timescale 1ns / 1ps

// Voxel face visibility editor.
// The input channel (in_valid, in_ready, in_data) takes one item: a place or
// destroy selector and a picked face id. The result channel (out_valid,
// out_ready, out_data) returns one item per input: status, changed voxel and
// the visible face count after the edit.
// The configuration port writes grid_side (index 0) or culling_on (index 1).
// A grid_side write, and reset, start a refill that sets all side^3 voxels
// solid, during which in_ready is low.
// An item's pick id is split into a voxel index and a face by a division
// by six. The two 13-step serial divisions by the side yield the voxel
// coordinates, and the neighbour scan makes six single-port occupancy reads
// to count the visible faces. A pick is ignored when the id is out of range
// or the voxel is empty; a place is refused when the neighbouring voxel lies
// outside the grid or is solid. One item is in work at a time, so the block
// takes no new item before the last one has been worked.
// The result sits in an output register. If the receiver stalls, the block
// still takes and works the next item, then waits with it in its last state
// and keeps in_ready low until the register is free.
module voxel_face_visibility_editor_core #(
  parameter int MAX_SIDE = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vfv_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vfv_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata
);

  vfv_pkg::cmd_t cmd;
  vfv_pkg::sts_t sts;

  // Sequencer.
  vfv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath with the occupancy memory.
  vfv_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An ignored item reports no voxel.
  a_ign_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == vfv_pkg::ST_IGNORED) |-> out_data.changed_voxel == '0)
    else $error("ignored item carries a voxel");

  // A result only appears while an item is in work.
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without an item in work");

  // A side write starts a refill that blocks the input.
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == vfv_pkg::REG_GRID_SIDE) |=> !in_ready)
    else $error("input open during refill");

endmodule
